>>> rtl/core/slice_gap_volume_splitter_defines.svh
// Assertion macros for the slice gap volume splitter checker.
// Needs nothing else; the including file supplies clock and reset names.
`ifndef SLICE_GAP_VOLUME_SPLITTER_DEFINES_SVH
`define SLICE_GAP_VOLUME_SPLITTER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SGVS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sgvs port check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SGVS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sgvs port check failed");

`endif

>>> rtl/core/sgvs_pkg.sv
// Shared types and constants of the slice gap volume splitter.
// No dependencies; imported by the testbench and by every module and interface file but the checker.
`timescale 1ns / 1ps
`default_nettype none

package sgvs_pkg;

  localparam int unsigned POSITION_FRACTION_BITS  = 16;
  localparam int unsigned DIRECTION_FRACTION_BITS = 14;

  localparam int unsigned POS_W       = 32;
  localparam int unsigned DIR_W       = 16;
  localparam int unsigned SLICE_POS_W = 40;
  localparam int unsigned SPACING_W   = 41;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned TOL_W       = 24;

  localparam int unsigned QUEUE_DEPTH = 8;

  // Roughly 0.01 mm at the position scaling, rounded to nearest.
  localparam logic [TOL_W-1:0] GAP_TOLERANCE_RESET =
    TOL_W'(((64'd1 << POSITION_FRACTION_BITS) + 64'd50) / 64'd100);

  typedef logic signed [POS_W-1:0]       pos_t;
  typedef logic signed [DIR_W-1:0]       dir_t;
  typedef logic signed [SLICE_POS_W-1:0] slice_pos_t;
  typedef logic [COUNT_W-1:0]            count_t;
  typedef logic [TOL_W-1:0]              tol_t;

  typedef struct packed {
    logic       new_volume;
    count_t     slice_number;
    count_t     volume_index;
    slice_pos_t slice_position;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/sgvs_ifs.sv
// Valid/ready channel interfaces for slice beats in and result beats out.
// Depends on sgvs_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface sgvs_in_if;
  import sgvs_pkg::*;

  logic valid;
  logic ready;
  pos_t pos_x;
  pos_t pos_y;
  pos_t pos_z;
  dir_t row_dir_x;
  dir_t row_dir_y;
  dir_t row_dir_z;
  dir_t col_dir_x;
  dir_t col_dir_y;
  dir_t col_dir_z;

  modport source (
    output valid, pos_x, pos_y, pos_z, row_dir_x, row_dir_y, row_dir_z,
           col_dir_x, col_dir_y, col_dir_z,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, row_dir_x, row_dir_y, row_dir_z,
           col_dir_x, col_dir_y, col_dir_z,
    output ready
  );
endinterface

interface sgvs_out_if;
  import sgvs_pkg::*;

  logic       valid;
  logic       ready;
  logic       new_volume;
  count_t     slice_number;
  count_t     volume_index;
  slice_pos_t slice_position;

  modport source (
    output valid, new_volume, slice_number, volume_index, slice_position,
    input  ready
  );
  modport sink (
    input  valid, new_volume, slice_number, volume_index, slice_position,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/slice_gap_volume_splitter.sv
// Slice gap volume splitter: one slice beat in (position and two direction
// vectors), one result beat out (new volume flag, slice number, volume index,
// projection on the slice normal). Both channels are valid/ready; a beat moves
// at a rising edge with valid and ready both high.
// gap_tolerance_i is written at any rising edge with gap_tolerance_we_i high;
// write it only while no result is outstanding.
// Path: an accepted slice beat passes four pipeline stages of projection
// arithmetic, one queue write, then the result register. Throughput is one slice
// per cycle while the receiver keeps up, set by the spacing and gap test in the
// back end.
// When the receiver stalls, the result register holds and the queue fills; the
// input drops ready once queued plus in-flight beats reach the queue depth.
// Reset clears the counters, the learned spacing and the queue, and loads the
// tolerance with its default of about 0.01 mm. The block accepts beats in the
// first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module slice_gap_volume_splitter #(
  parameter int unsigned DIRECTION_FRACTION_BITS = sgvs_pkg::DIRECTION_FRACTION_BITS,
  parameter int unsigned QUEUE_DEPTH             = sgvs_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           gap_tolerance_we_i,
  input  wire sgvs_pkg::tol_t gap_tolerance_i,
  sgvs_in_if.sink             in_i,
  sgvs_out_if.source          out_o
);
  import sgvs_pkg::*;

  logic       push;
  slice_pos_t push_data;
  logic       pop;
  logic       not_empty;
  slice_pos_t head;

  sgvs_front #(
    .DIRECTION_FRACTION_BITS (DIRECTION_FRACTION_BITS),
    .QUEUE_DEPTH             (QUEUE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .pop_i       (pop),
    .push_o      (push),
    .push_data_o (push_data)
  );

  sgvs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .not_empty_o (not_empty),
    .head_o      (head)
  );

  sgvs_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .gap_tolerance_we_i (gap_tolerance_we_i),
    .gap_tolerance_i    (gap_tolerance_i),
    .not_empty_i        (not_empty),
    .head_i             (head),
    .pop_o              (pop),
    .out_o              (out_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/sgvs_front.sv
// Front end: accepts slice beats and computes the projection on the slice normal.
// Four-stage pipeline with credit against the queue; depends on sgvs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sgvs_front #(
  parameter int unsigned DIRECTION_FRACTION_BITS = sgvs_pkg::DIRECTION_FRACTION_BITS,
  parameter int unsigned QUEUE_DEPTH             = sgvs_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  sgvs_in_if.sink                  in_i,
  input  wire logic                pop_i,
  output logic                     push_o,
  output sgvs_pkg::slice_pos_t     push_data_o
);
  import sgvs_pkg::*;

  localparam int unsigned DFB   = DIRECTION_FRACTION_BITS;
  localparam int unsigned PROD_W = 2 * DIR_W;
  localparam int unsigned DIFF_W = PROD_W + 2;
  localparam int unsigned NRM_W  = DIFF_W - DFB;
  localparam int unsigned PN_W   = POS_W + NRM_W;
  localparam int unsigned ACC_W  = PN_W + 2;
  localparam int unsigned OCC_W  = $clog2(QUEUE_DEPTH + 1);

  localparam logic signed [DIFF_W-1:0] HALF_N = DIFF_W'(1) << (DFB - 1);
  localparam logic signed [ACC_W-1:0]  HALF_A = ACC_W'(1) << (DFB - 1);
  localparam logic signed [ACC_W-1:0]  POS_MAX =
    {{(ACC_W - SLICE_POS_W + 1){1'b0}}, {(SLICE_POS_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0]  POS_MIN =
    {{(ACC_W - SLICE_POS_W + 1){1'b1}}, {(SLICE_POS_W - 1){1'b0}}};

  logic                      accept;
  logic [OCC_W-1:0]          occ_q, occ_d;
  logic [3:0]                vld_q;

  pos_t                      p1_q [3];
  pos_t                      p2_q [3];
  logic signed [PROD_W-1:0]  prod_q [6];
  logic signed [NRM_W-1:0]   nrm_q [3];
  logic signed [PN_W-1:0]    pn_q [3];
  slice_pos_t                pos_q;

  logic signed [DIFF_W-1:0]  diff [3];
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   shifted;
  logic signed [ACC_W-1:0]   clamped;

  // Credit covers beats in the pipeline as well as those already queued.
  assign in_i.ready = (occ_q < OCC_W'(QUEUE_DEPTH));
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    occ_d = occ_q;
    if (accept && !pop_i) begin
      occ_d = occ_q + OCC_W'(1);
    end else if (!accept && pop_i) begin
      occ_d = occ_q - OCC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      vld_q <= '0;
    end else begin
      occ_q <= occ_d;
      vld_q <= {vld_q[2:0], accept};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = DIFF_W'(prod_q[2*i]) - DIFF_W'(prod_q[2*i+1]) + HALF_N;
    end
    acc = ACC_W'(pn_q[0]) + ACC_W'(pn_q[1]) + ACC_W'(pn_q[2]) + HALF_A;
    shifted = acc >>> DFB;
    if (shifted > POS_MAX) begin
      clamped = POS_MAX;
    end else if (shifted < POS_MIN) begin
      clamped = POS_MIN;
    end else begin
      clamped = shifted;
    end
  end

  // Stage one forms the six cross products, stage two rounds the normal,
  // stage three multiplies by the position, stage four sums and saturates.
  always_ff @(posedge clk_i) begin
    p1_q[0]   <= in_i.pos_x;
    p1_q[1]   <= in_i.pos_y;
    p1_q[2]   <= in_i.pos_z;
    prod_q[0] <= in_i.row_dir_y * in_i.col_dir_z;
    prod_q[1] <= in_i.row_dir_z * in_i.col_dir_y;
    prod_q[2] <= in_i.row_dir_z * in_i.col_dir_x;
    prod_q[3] <= in_i.row_dir_x * in_i.col_dir_z;
    prod_q[4] <= in_i.row_dir_x * in_i.col_dir_y;
    prod_q[5] <= in_i.row_dir_y * in_i.col_dir_x;
    for (int i = 0; i < 3; i++) begin
      p2_q[i]  <= p1_q[i];
      nrm_q[i] <= NRM_W'(diff[i] >>> DFB);
      pn_q[i]  <= p2_q[i] * nrm_q[i];
    end
    pos_q <= clamped[SLICE_POS_W-1:0];
  end

  assign push_o      = vld_q[3];
  assign push_data_o = pos_q;

endmodule

`default_nettype wire

>>> rtl/core/sgvs_queue.sv
// Short first-in first-out queue of projections between front and back end.
// Register array with combinational head; depends on sgvs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sgvs_queue #(
  parameter int unsigned DEPTH = sgvs_pkg::QUEUE_DEPTH
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire sgvs_pkg::slice_pos_t push_data_i,
  input  wire logic                 pop_i,
  output logic                      not_empty_o,
  output sgvs_pkg::slice_pos_t      head_o
);
  import sgvs_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  slice_pos_t    mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] ptr);
    logic [AW-1:0] nxt;
    nxt = (ptr == AW'(DEPTH - 1)) ? '0 : ptr + AW'(1);
    return nxt;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wrap_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= wrap_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // The front end's credit keeps a push from ever meeting a full queue.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign not_empty_o = (cnt_q != '0);
  assign head_o      = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

>>> rtl/core/sgvs_back.sv
// Back end: spacing learning, gap test, slice and volume counters, result register.
// Holds the gap tolerance register; depends on sgvs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sgvs_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 gap_tolerance_we_i,
  input  wire sgvs_pkg::tol_t       gap_tolerance_i,
  input  wire logic                 not_empty_i,
  input  wire sgvs_pkg::slice_pos_t head_i,
  output logic                      pop_o,
  sgvs_out_if.source                out_o
);
  import sgvs_pkg::*;

  localparam int unsigned DEV_W = SPACING_W + 1;
  localparam count_t      COUNT_MAX = '1;

  typedef logic signed [SPACING_W-1:0] spacing_t;

  tol_t        tol_q;
  logic        open_q;
  slice_pos_t  prev_q;
  spacing_t    learned_q, learned_d;
  count_t      slice_q, vol_q;
  logic        out_valid_q;
  result_t     res_q, res_d;

  spacing_t               spacing;
  logic                   learn;
  logic signed [DEV_W-1:0] dev;
  logic [DEV_W-1:0]       dev_mag;
  logic                   start;

  assign pop_o = not_empty_i && (!out_valid_q || out_o.ready);

  always_comb begin
    spacing   = SPACING_W'(head_i) - SPACING_W'(prev_q);
    learn     = open_q && (learned_q == '0);
    learned_d = learn ? spacing : learned_q;
    dev       = DEV_W'(spacing) - DEV_W'(learned_d);
    dev_mag   = dev[DEV_W-1] ? DEV_W'(-dev) : DEV_W'(dev);
    start     = !open_q || (dev_mag > DEV_W'(tol_q));

    res_d.new_volume     = start;
    res_d.slice_number   = start ? '0 : slice_q;
    res_d.volume_index   = (start && open_q && (vol_q != COUNT_MAX)) ?
                           vol_q + COUNT_W'(1) : vol_q;
    res_d.slice_position = head_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q       <= GAP_TOLERANCE_RESET;
      open_q      <= 1'b0;
      prev_q      <= '0;
      learned_q   <= '0;
      slice_q     <= '0;
      vol_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (gap_tolerance_we_i) begin
        tol_q <= gap_tolerance_i;
      end
      if (pop_o) begin
        open_q    <= 1'b1;
        prev_q    <= head_i;
        learned_q <= learned_d;
        vol_q     <= res_d.volume_index;
        slice_q   <= (res_d.slice_number == COUNT_MAX) ?
                     COUNT_MAX : res_d.slice_number + COUNT_W'(1);
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.new_volume     = res_q.new_volume;
  assign out_o.slice_number   = res_q.slice_number;
  assign out_o.volume_index   = res_q.volume_index;
  assign out_o.slice_position = res_q.slice_position;

endmodule

`default_nettype wire

>>> rtl/core/sgvs_checker.sv
// Port-level checks on the result channel of the slice gap volume splitter.
// Uses the macros of slice_gap_volume_splitter_defines.svh; bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "slice_gap_volume_splitter_defines.svh"

module sgvs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic        new_volume_i,
  input wire logic [15:0] slice_number_i,
  input wire logic [39:0] slice_position_i
);

  // A new volume always restarts slice numbering.
  `SGVS_ASSERT_IMP(a_new_volume_slice_zero, clk_i, rst_ni, out_valid_i && new_volume_i, slice_number_i == 16'd0)

  // A continuing slice has at least one slice before it in the volume.
  `SGVS_ASSERT_IMP(a_continue_slice_nonzero, clk_i, rst_ni, out_valid_i && !new_volume_i, slice_number_i != 16'd0)

  // A stalled result beat stays put.
  `SGVS_ASSERT_NXT(a_stall_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(slice_position_i) && $stable(slice_number_i))

endmodule

bind slice_gap_volume_splitter sgvs_checker u_sgvs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .new_volume_i     (out_o.new_volume),
  .slice_number_i   (out_o.slice_number),
  .slice_position_i (out_o.slice_position)
);

`default_nettype wire

>>> tb/slice_gap_volume_splitter_tb.sv
// Self-checking testbench for the slice gap volume splitter: random and directed slice beats,
// a scoreboard class that predicts each result, and random idling on both channels.
// Depends on sgvs_pkg, the channel interfaces in sgvs_ifs.sv and the block's top level.
`timescale 1ns / 1ps

module slice_gap_volume_splitter_tb;
  import sgvs_pkg::*;

  localparam int unsigned CLK_HALF        = 10;
  localparam int unsigned RESET_CYCLES    = 6;
  localparam longint      NOMINAL_STEP    = 262144;   // 4 mm at 16 fractional bits
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES    = 10;
  localparam int unsigned PHASE_ITEMS     = 140;
  localparam int unsigned MAX_REPORTS     = 30;
  localparam int unsigned COUNT_MAX       = 65535;
  localparam longint      PROJ_LIMIT      = 64'sd1 << 30;
  localparam longint      SLICE_POS_MAX   = (64'sd1 <<< (SLICE_POS_W - 1)) - 1;
  localparam longint      SLICE_POS_MIN   = -(64'sd1 <<< (SLICE_POS_W - 1));
  localparam int          DIR_ONE         = 1 << DIRECTION_FRACTION_BITS;
  localparam tol_t        TOL_MAX         = '1;

  typedef enum {IDLE_SENDER_LIGHT, IDLE_SENDER_HEAVY, IDLE_NONE} idling_e;

  typedef struct {
    pos_t pos[3];
    dir_t row[3];
    dir_t col[3];
  } slice_beat_t;

  // Predicts one result per slice beat and holds the results still to come.
  class splitter_scoreboard;
    longint  tolerance;
    bit      volume_open;
    longint  previous_position;
    longint  learned_spacing;
    int      slice_count;
    int      volume_count;
    result_t expected_results[$];
    int      errors;
    int      checked;
    int      volume_starts;
    int      reports;

    function new();
      tolerance         = longint'(GAP_TOLERANCE_RESET);
      volume_open       = 1'b0;
      previous_position = 0;
      learned_spacing   = 0;
      slice_count       = 0;
      volume_count      = 0;
      errors            = 0;
      checked           = 0;
      volume_starts     = 0;
      reports           = 0;
    endfunction

    function void set_tolerance(tol_t value);
      tolerance = longint'(value);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Round half toward plus infinity, then drop the fractional bits.
    function longint round_off(longint x, int unsigned bits);
      return (x + (64'sd1 <<< (bits - 1))) >>> bits;
    endfunction

    function void note_slice(slice_beat_t s);
      longint  p[3];
      longint  u[3];
      longint  v[3];
      longint  n[3];
      longint  projection;
      longint  spacing;
      longint  deviation;
      bit      starts;
      result_t r;
      for (int i = 0; i < 3; i++) begin
        p[i] = longint'(s.pos[i]);
        u[i] = longint'(s.row[i]);
        v[i] = longint'(s.col[i]);
      end
      n[0] = round_off(u[1] * v[2] - u[2] * v[1], DIRECTION_FRACTION_BITS);
      n[1] = round_off(u[2] * v[0] - u[0] * v[2], DIRECTION_FRACTION_BITS);
      n[2] = round_off(u[0] * v[1] - u[1] * v[0], DIRECTION_FRACTION_BITS);
      projection = round_off(p[0] * n[0] + p[1] * n[1] + p[2] * n[2],
                             DIRECTION_FRACTION_BITS);
      if (projection > SLICE_POS_MAX) projection = SLICE_POS_MAX;
      if (projection < SLICE_POS_MIN) projection = SLICE_POS_MIN;

      spacing = projection - previous_position;
      // The spacing is learned once; a zero difference leaves it unlearned.
      if (volume_open && learned_spacing == 0) learned_spacing = spacing;
      deviation = spacing - learned_spacing;
      if (deviation < 0) deviation = -deviation;

      starts = !volume_open || (deviation > tolerance);
      if (starts) begin
        if (volume_open && volume_count < COUNT_MAX) volume_count++;
        slice_count = 0;
        volume_open = 1'b1;
      end

      r.new_volume     = starts;
      r.slice_number   = count_t'(slice_count);
      r.volume_index   = count_t'(volume_count);
      r.slice_position = slice_pos_t'(projection);
      expected_results.insert(expected_results.size(), r);

      if (slice_count < COUNT_MAX) slice_count++;
      previous_position = projection;
    endfunction

    function void report(string field, longint want, longint seen);
      errors++;
      if (reports < MAX_REPORTS) begin
        reports++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t ns: result beat with nothing expected, expected none, actual %0h",
                   $time, got);
        end
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (got.new_volume) volume_starts++;
      if (got.new_volume !== want.new_volume)
        report("new_volume", longint'(want.new_volume), longint'(got.new_volume));
      if (got.slice_number !== want.slice_number)
        report("slice_number", longint'(want.slice_number), longint'(got.slice_number));
      if (got.volume_index !== want.volume_index)
        report("volume_index", longint'(want.volume_index), longint'(got.volume_index));
      if (got.slice_position !== want.slice_position)
        report("slice_position", longint'(want.slice_position), longint'(got.slice_position));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic tol_we;
  tol_t tol_data;

  sgvs_in_if  slice_if ();
  sgvs_out_if result_if ();

  slice_gap_volume_splitter i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .gap_tolerance_we_i (tol_we),
    .gap_tolerance_i    (tol_data),
    .in_i               (slice_if),
    .out_o              (result_if)
  );

  splitter_scoreboard sb;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stalls_asked;
  int unsigned stalls_done  = 0;
  int unsigned stall_left   = 0;
  int unsigned quiet_cycles = 0;

  // State of the well-formed slice sequence being generated.
  int     seq_axis;
  int     seq_sign;
  longint seq_proj;
  int     seq_left;

  always #(CLK_HALF) clk_i = ~clk_i;

  // Receiver: random idling, plus a long counted hold-off on request.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      result_if.ready <= 1'b0;
    end else if (stalls_asked != stalls_done) begin
      stalls_done = stalls_done + 1;
      stall_left  = HOLD_OFF_CYCLES;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : monitor
    slice_beat_t seen;
    result_t     got;
    if (rst_ni) begin
      if (slice_if.valid && slice_if.ready) begin
        seen.pos[0] = slice_if.pos_x;
        seen.pos[1] = slice_if.pos_y;
        seen.pos[2] = slice_if.pos_z;
        seen.row[0] = slice_if.row_dir_x;
        seen.row[1] = slice_if.row_dir_y;
        seen.row[2] = slice_if.row_dir_z;
        seen.col[0] = slice_if.col_dir_x;
        seen.col[1] = slice_if.col_dir_y;
        seen.col[2] = slice_if.col_dir_z;
        sb.note_slice(seen);
      end
      if (result_if.valid && result_if.ready) begin
        got.new_volume     = result_if.new_volume;
        got.slice_number   = result_if.slice_number;
        got.volume_index   = result_if.volume_index;
        got.slice_position = result_if.slice_position;
        sb.check_result(got);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((slice_if.valid && slice_if.ready) || (result_if.valid && result_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("slice_gap_volume_splitter verification failed");
      $finish;
    end
  end

  function automatic slice_beat_t make_slice(longint px, longint py, longint pz,
                                             int rx, int ry, int rz, int cx, int cy, int cz);
    slice_beat_t s;
    s.pos[0] = pos_t'(px);
    s.pos[1] = pos_t'(py);
    s.pos[2] = pos_t'(pz);
    s.row[0] = dir_t'(rx);
    s.row[1] = dir_t'(ry);
    s.row[2] = dir_t'(rz);
    s.col[0] = dir_t'(cx);
    s.col[1] = dir_t'(cy);
    s.col[2] = dir_t'(cz);
    return s;
  endfunction

  // Directions chosen so that the normal lies on one axis and the projection
  // equals sign times the position component on that axis.
  function automatic slice_beat_t axis_slice(int axis, int sign, longint proj);
    slice_beat_t s;
    for (int i = 0; i < 3; i++) begin
      s.pos[i] = pos_t'($urandom);
      s.row[i] = '0;
      s.col[i] = '0;
    end
    case (axis)
      0: begin
        s.row[1] = dir_t'(sign * DIR_ONE);
        s.col[2] = dir_t'(DIR_ONE);
      end
      1: begin
        s.row[2] = dir_t'(sign * DIR_ONE);
        s.col[0] = dir_t'(DIR_ONE);
      end
      default: begin
        s.row[0] = dir_t'(sign * DIR_ONE);
        s.col[1] = dir_t'(DIR_ONE);
      end
    endcase
    s.pos[axis] = pos_t'(sign * proj);
    return s;
  endfunction

  function automatic void start_sequence();
    seq_axis = $urandom_range(0, 2);
    seq_sign = $urandom_range(0, 1) ? 1 : -1;
    seq_proj = longint'($urandom_range(0, 1 << 30)) - (64'sd1 << 29);
    seq_left = $urandom_range(2, 40);
  endfunction

  // Mostly evenly spaced series with jitter around the tolerance, some gaps,
  // and a quarter of pure noise.
  function automatic slice_beat_t random_slice(longint tol);
    longint jitter;
    int     r;
    if ($urandom_range(0, 99) < 25)
      return make_slice(longint'(int'($urandom)), longint'(int'($urandom)),
                        longint'(int'($urandom)), int'($urandom), int'($urandom),
                        int'($urandom), int'($urandom), int'($urandom), int'($urandom));
    if (seq_left == 0) begin
      start_sequence();
    end else begin
      r = $urandom_range(0, 99);
      if (r < 8)       jitter = tol + 1 + longint'($urandom_range(0, 1 << 20));
      else if (r < 12) jitter = tol + 1;
      else if (r < 18) jitter = tol;
      else             jitter = longint'($urandom_range(0, 32'(2 * tol))) - tol;
      if (r < 18 && $urandom_range(0, 1) == 1) jitter = -jitter;
      seq_proj = seq_proj + NOMINAL_STEP + jitter;
      if (seq_proj > PROJ_LIMIT || seq_proj < -PROJ_LIMIT) start_sequence();
    end
    seq_left = seq_left - 1;
    return axis_slice(seq_axis, seq_sign, seq_proj);
  endfunction

  task automatic set_idling(idling_e mode);
    case (mode)
      IDLE_SENDER_LIGHT: begin
        send_idle_pct = 23;
        recv_idle_pct = 83;
      end
      IDLE_SENDER_HEAVY: begin
        send_idle_pct = 83;
        recv_idle_pct = 23;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // Leaves valid high on return so that back-to-back beats need no gap.
  task automatic send_slice(slice_beat_t s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      slice_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    slice_if.valid     <= 1'b1;
    slice_if.pos_x     <= s.pos[0];
    slice_if.pos_y     <= s.pos[1];
    slice_if.pos_z     <= s.pos[2];
    slice_if.row_dir_x <= s.row[0];
    slice_if.row_dir_y <= s.row[1];
    slice_if.row_dir_z <= s.row[2];
    slice_if.col_dir_x <= s.col[0];
    slice_if.col_dir_y <= s.col[1];
    slice_if.col_dir_z <= s.col[2];
    @(posedge clk_i);
    while (!slice_if.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    slice_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_tolerance(tol_t value);
    @(posedge clk_i);
    tol_we   <= 1'b1;
    tol_data <= value;
    @(posedge clk_i);
    tol_we   <= 1'b0;
    sb.set_tolerance(value);
  endtask

  initial begin : stimulus
    tol_t        phase_tol[6];
    idling_e     phase_mode[6];
    longint      track;

    sb           = new();
    rst_ni       = 1'b0;
    tol_we       = 1'b0;
    tol_data     = '0;
    stalls_asked = 0;
    seq_left     = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    slice_if.valid     = 1'b0;
    slice_if.pos_x     = '0;
    slice_if.pos_y     = '0;
    slice_if.pos_z     = '0;
    slice_if.row_dir_x = '0;
    slice_if.row_dir_y = '0;
    slice_if.row_dir_z = '0;
    slice_if.col_dir_x = '0;
    slice_if.col_dir_y = '0;
    slice_if.col_dir_z = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, at the reset tolerance of 655.
    set_idling(IDLE_SENDER_LIGHT);
    track = 0;
    send_slice(axis_slice(2, 1, track));                 // first slice opens volume 0
    send_slice(axis_slice(2, 1, track));                 // zero step, spacing not learned
    track = track + NOMINAL_STEP;
    send_slice(axis_slice(2, 1, track));                 // spacing learned here
    track = track + NOMINAL_STEP + 655;
    send_slice(axis_slice(2, 1, track));                 // deviation equal to tolerance
    track = track + NOMINAL_STEP + 656;
    send_slice(axis_slice(2, 1, track));                 // just beyond, new volume
    track = track + NOMINAL_STEP - 656;
    send_slice(axis_slice(2, 1, track));
    track = track + NOMINAL_STEP - 655;
    send_slice(axis_slice(2, 1, track));
    track = track + NOMINAL_STEP;
    send_slice(axis_slice(2, 1, track));
    send_slice(make_slice(2147483647, 2147483647, 2147483647,
                          32767, -32768, 32767, -32768, 32767, -32768));
    send_slice(make_slice(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                          32767, -32768, 32767, -32768, 32767, -32768));
    send_slice(make_slice(2147483647, -64'sd2147483648, 2147483647,
                          -32768, 32767, -32768, 32767, -32768, -32768));
    send_slice(make_slice(123456789, -987654321, 55555, 0, 0, 0, 0, 0, 0));
    // Halves in both rounding steps, on either side of zero.
    send_slice(make_slice(0, 0, 8192, 1, 0, 0, 0, 8192, 0));
    send_slice(make_slice(0, 0, 77777, -1, 0, 0, 0, 8192, 0));
    send_slice(make_slice(0, 0, -8192, 1, 0, 0, 0, 8192, 0));
    send_slice(axis_slice(0, -1, 1000));
    send_slice(axis_slice(1, 1, -1000));
    send_slice(axis_slice(2, 1, 2147483647));
    send_slice(axis_slice(2, 1, -64'sd2147483648));
    send_slice(make_slice(0, 0, 5, DIR_ONE, 0, 0, 0, -DIR_ONE, 0));
    drain();

    phase_tol[0]  = tol_t'($urandom_range(1000, 200000));
    phase_tol[1]  = '0;
    phase_tol[2]  = TOL_MAX;
    phase_tol[3]  = tol_t'($urandom);
    phase_tol[4]  = GAP_TOLERANCE_RESET;
    phase_tol[5]  = tol_t'($urandom_range(1, 5000));
    phase_mode[0] = IDLE_SENDER_LIGHT;
    phase_mode[1] = IDLE_SENDER_HEAVY;
    phase_mode[2] = IDLE_NONE;
    phase_mode[3] = IDLE_SENDER_LIGHT;
    phase_mode[4] = IDLE_SENDER_HEAVY;
    phase_mode[5] = IDLE_NONE;

    for (int ph = 0; ph < 6; ph++) begin
      write_tolerance(phase_tol[ph]);
      set_idling(phase_mode[ph]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // One long receiver hold-off while beats keep coming, to fill the queue.
        if (ph == 2 && k == 60) stalls_asked = stalls_asked + 1;
        send_slice(random_slice(longint'(phase_tol[ph])));
      end
      drain();
    end

    $display("Checked %0d results, %0d of them volume starts, over tolerances from 0 to %0d,",
             sb.checked, sb.volume_starts, TOL_MAX);
    $display("with idling on either side, edge values of every field and a long receiver hold-off.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("slice_gap_volume_splitter verification clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.errors, sb.pending());
      $display("slice_gap_volume_splitter verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/sgvs_pkg.sv
rtl/core/sgvs_ifs.sv
rtl/core/sgvs_front.sv
rtl/core/sgvs_queue.sv
rtl/core/sgvs_back.sv
rtl/core/slice_gap_volume_splitter.sv
rtl/core/sgvs_checker.sv
tb/slice_gap_volume_splitter_tb.sv
